// ===== rtl/tkdb_pkg.sv =====
// ----------------------------------------------------------------------------
// tkdb_pkg
// Shared constants and types for the top-k difficulty board: board depth,
// derived widths, the ranked entry record and the per-cell control group.
// ----------------------------------------------------------------------------
package tkdb_pkg;

    // board geometry
    localparam int BOARD_DEPTH = 16;
    localparam int IDX_W       = (BOARD_DEPTH > 1) ? $clog2(BOARD_DEPTH) : 1;
    localparam int COUNT_W     = $clog2(BOARD_DEPTH + 1);

    // command codes
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // one ranked share
    typedef struct packed {
        logic [63:0]      difficulty;
        logic [63:0]      job;
        logic [63:0]      extranonce;
        logic [31:0]      ntime;
        logic [31:0]      nonce;
        logic [31:0]      version;
        logic [IDX_W-1:0] slot;
    } t_entry;

    // broadcast from the top to every cell
    typedef struct packed {
        logic   shift;
        t_entry incoming;
    } t_cell_ctrl;

endpackage

// ===== rtl/tkdb_in_if.sv =====
// ----------------------------------------------------------------------------
// tkdb_in_if
// Request channel of the difficulty board: valid/ready plus the command,
// the share fields and the rank to read.
// ----------------------------------------------------------------------------
interface tkdb_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [63:0] share_difficulty;
    logic [63:0] job_tag;
    logic [63:0] extranonce_tag;
    logic [31:0] share_time;
    logic [31:0] share_nonce;
    logic [31:0] share_version;
    logic [3:0]  read_index;

    modport source (
        output valid, cmd, share_difficulty, job_tag, extranonce_tag,
               share_time, share_nonce, share_version, read_index,
        input  ready
    );

    modport sink (
        input  valid, cmd, share_difficulty, job_tag, extranonce_tag,
               share_time, share_nonce, share_version, read_index,
        output ready
    );
endinterface

// ===== rtl/tkdb_out_if.sv =====
// ----------------------------------------------------------------------------
// tkdb_out_if
// Result channel of the difficulty board: valid/ready plus the add status
// and the contents of a read rank.
// ----------------------------------------------------------------------------
interface tkdb_out_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [3:0]  taken_slot;
    logic [4:0]  new_rank;
    logic [4:0]  filled;
    logic [63:0] rd_difficulty;
    logic [63:0] rd_job;
    logic [63:0] rd_extranonce;
    logic [31:0] rd_time;
    logic [31:0] rd_nonce;
    logic [31:0] rd_version;
    logic [3:0]  rd_slot;

    modport source (
        output valid, accepted, taken_slot, new_rank, filled, rd_difficulty,
               rd_job, rd_extranonce, rd_time, rd_nonce, rd_version, rd_slot,
        input  ready
    );

    modport sink (
        input  valid, accepted, taken_slot, new_rank, filled, rd_difficulty,
               rd_job, rd_extranonce, rd_time, rd_nonce, rd_version, rd_slot,
        output ready
    );
endinterface

// ===== rtl/tkdb_cell.sv =====
// ----------------------------------------------------------------------------
// tkdb_cell
// One rank of the sorted board. Compares its difficulty with the incoming
// share, then on an accepted add either keeps its entry, takes the new
// share, or takes its upper neighbour's entry.
// ----------------------------------------------------------------------------
module tkdb_cell (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [tkdb_pkg::IDX_W-1:0]         i_reset_slot,
    input  tkdb_pkg::t_cell_ctrl               i_ctrl,
    input  tkdb_pkg::t_entry                   i_prev_entry,
    input  logic                               i_prev_ge,
    output tkdb_pkg::t_entry                   o_entry,
    output logic                               o_ge,
    output logic                               o_ins
);

    tkdb_pkg::t_entry r_entry;
    tkdb_pkg::t_entry n_entry;

    // this rank stays ahead of the new share
    assign o_ge  = (r_entry.difficulty >= i_ctrl.incoming.difficulty);
    // first rank that the new share beats
    assign o_ins = !o_ge && i_prev_ge;

    // keep, insert or shift down
    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.shift && !o_ge) begin
            if (i_prev_ge) begin
                n_entry = i_ctrl.incoming;
            end else begin
                n_entry = i_prev_entry;
            end
        end
    end

    // entry register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry      <= '0;
            r_entry.slot <= i_reset_slot;
        end else begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

// ===== rtl/top_k_difficulty_board.sv =====
// ----------------------------------------------------------------------------
// top_k_difficulty_board
// Keeps the best shares sorted by descending difficulty and answers rank
// reads.
// ----------------------------------------------------------------------------
// Every rank cell compares against the new share in parallel and the whole
// chain shifts in the same edge, and a read selects one rank cell. One
// request is accepted per cycle while the result register is empty or being
// drained, so the sustained rate is one request per clock; the result is
// registered in the cycle after the request is taken. An add is taken only
// if its difficulty is strictly above the last rank; it lands after any
// equal entries and reuses the evicted rank's storage slot. Reads of a rank
// at or beyond the board depth return zeros. No start-up sweep: the board
// is ready right after reset.
// ----------------------------------------------------------------------------
module top_k_difficulty_board (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tkdb_in_if.sink     i_req,
    tkdb_out_if.source  o_rsp
);

    localparam int DEPTH = tkdb_pkg::BOARD_DEPTH;

    tkdb_pkg::t_entry                 w_entry [DEPTH];
    logic [DEPTH-1:0]                 w_ge;
    logic [DEPTH-1:0]                 w_ins;
    tkdb_pkg::t_cell_ctrl             w_ctrl;
    logic                             w_fire;
    logic                             w_is_add;
    logic                             w_accept;
    logic [tkdb_pkg::IDX_W-1:0]       w_pos;
    logic [tkdb_pkg::IDX_W-1:0]       w_rd_idx;
    logic                             w_rd_ok;
    tkdb_pkg::t_entry                 w_rd_entry;

    logic [tkdb_pkg::COUNT_W-1:0]     r_count;
    logic [tkdb_pkg::COUNT_W-1:0]     n_count;
    logic                             r_valid;
    logic                             r_accepted;
    logic [3:0]                       r_taken_slot;
    logic [4:0]                       r_new_rank;
    logic [4:0]                       r_filled;
    tkdb_pkg::t_entry                 r_rd;

    // handshake: take a request whenever the result register frees up
    assign i_req.ready = !r_valid || o_rsp.ready;
    assign w_fire      = i_req.valid && i_req.ready;
    assign w_is_add    = (i_req.cmd == tkdb_pkg::CMD_ADD);
    assign w_accept    = w_fire && w_is_add && !w_ge[DEPTH-1];

    // broadcast of the new share; it takes the last rank's slot
    always_comb begin
        w_ctrl                     = '0;
        w_ctrl.shift               = w_accept;
        w_ctrl.incoming.difficulty = i_req.share_difficulty;
        w_ctrl.incoming.job        = i_req.job_tag;
        w_ctrl.incoming.extranonce = i_req.extranonce_tag;
        w_ctrl.incoming.ntime      = i_req.share_time;
        w_ctrl.incoming.nonce      = i_req.share_nonce;
        w_ctrl.incoming.version    = i_req.share_version;
        w_ctrl.incoming.slot       = w_entry[DEPTH-1].slot;
    end

    // chain of rank cells
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            tkdb_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_reset_slot (tkdb_pkg::IDX_W'(g)),
                .i_ctrl       (w_ctrl),
                .i_prev_entry (w_ctrl.incoming),
                .i_prev_ge    (1'b1),
                .o_entry      (w_entry[g]),
                .o_ge         (w_ge[g]),
                .o_ins        (w_ins[g])
            );
        end else begin : g_body
            tkdb_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_reset_slot (tkdb_pkg::IDX_W'(g)),
                .i_ctrl       (w_ctrl),
                .i_prev_entry (w_entry[g-1]),
                .i_prev_ge    (w_ge[g-1]),
                .o_entry      (w_entry[g]),
                .o_ge         (w_ge[g]),
                .o_ins        (w_ins[g])
            );
        end
    end

    // encode the insertion rank from the one-hot boundary
    always_comb begin
        w_pos = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_ins[i]) begin
                w_pos = w_pos | tkdb_pkg::IDX_W'(i);
            end
        end
    end

    // rank read select
    assign w_rd_ok    = (int'(i_req.read_index) < DEPTH);
    assign w_rd_idx   = tkdb_pkg::IDX_W'(i_req.read_index);
    assign w_rd_entry = w_entry[w_rd_idx];

    // saturating fill count
    always_comb begin
        n_count = r_count;
        if (w_accept && (r_count != tkdb_pkg::COUNT_W'(DEPTH))) begin
            n_count = r_count + 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_fire) begin
                r_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_accepted   <= w_accept;
            r_taken_slot <= w_accept ? 4'(w_entry[DEPTH-1].slot) : 4'd0;
            r_new_rank   <= w_accept ? 5'(tkdb_pkg::COUNT_W'(w_pos) + 1'b1) : 5'd0;
            r_filled     <= 5'(n_count);
            r_rd         <= (!w_is_add && w_rd_ok) ? w_rd_entry : '0;
        end
    end

    assign o_rsp.valid         = r_valid;
    assign o_rsp.accepted      = r_accepted;
    assign o_rsp.taken_slot    = r_taken_slot;
    assign o_rsp.new_rank      = r_new_rank;
    assign o_rsp.filled        = r_filled;
    assign o_rsp.rd_difficulty = r_rd.difficulty;
    assign o_rsp.rd_job        = r_rd.job;
    assign o_rsp.rd_extranonce = r_rd.extranonce;
    assign o_rsp.rd_time       = r_rd.ntime;
    assign o_rsp.rd_nonce      = r_rd.nonce;
    assign o_rsp.rd_version    = r_rd.version;
    assign o_rsp.rd_slot       = 4'(r_rd.slot);

endmodule

// ===== rtl/tkdb_checker.sv =====
// ----------------------------------------------------------------------------
// tkdb_checker
// Port-level checks for the difficulty board, bound to the top level.
// ----------------------------------------------------------------------------
module tkdb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_accepted,
    input logic [3:0] i_taken_slot,
    input logic [4:0] i_new_rank,
    input logic [4:0] i_filled
);

    // a stalled result holds its status
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_accepted) && $stable(i_new_rank)
             && $stable(i_filled)))
        else $error("stalled result changed");

    // a result only follows a request
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready))
        else $error("result without request");

    // an accepted share ranks within the filled board
    a_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_accepted) |->
            (i_new_rank != 5'd0 && i_new_rank <= i_filled))
        else $error("accepted share rank out of range");

    // no add status without acceptance
    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_accepted) |->
            (i_new_rank == 5'd0 && i_taken_slot == 4'd0))
        else $error("rejected result carries add status");

    // fill count never passes the board depth
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (int'(i_filled) <= tkdb_pkg::BOARD_DEPTH))
        else $error("fill count beyond board depth");

endmodule

bind top_k_difficulty_board tkdb_checker u_tkdb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_accepted   (o_rsp.accepted),
    .i_taken_slot (o_rsp.taken_slot),
    .i_new_rank   (o_rsp.new_rank),
    .i_filled     (o_rsp.filled)
);
